### hdl/lphc_pkg.sv
// Shared types, constants and helper functions for the linear probe hash cache.
package lphc_pkg;

    // Table geometry; the depth is a power of two so the home slot is a mask of the hash
    localparam int TABLE_DEPTH = 256;
    localparam int KEY_BYTES   = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SLOT_W      = 8;

    // djb2 hash setup: every byte of both 8-byte key words is walked, zeros skipped
    localparam logic [63:0] HASH_START = 64'd5381;
    localparam int          HASH_SHIFT = 5;
    localparam int          HASH_STEPS = 16;
    localparam int          STEP_W     = $clog2(HASH_STEPS);

    // One stored entry: {payload, second key, first key}
    localparam int ENTRY_W = 192;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_CLEAR  = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_INIT  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CHK
    } t_state;

    // Input beat
    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] first_key;
        logic [63:0] second_key;
        logic [63:0] payload_in;
    } t_in;

    // Result beat
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] payload_out;
        logic [7:0]  slot;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    clear;
        logic    hash_step;
        logic    rd_en;
        logic    advance;
        logic    wr_en;
        logic    finish;
        t_status fin_status;
        logic    fin_payload;
        logic    fin_slot;
    } t_ctl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic ready;
        logic hash_last;
        logic occupied;
        logic match;
        logic lap_last;
    } t_ctl_sts;

    // Keep the bytes before the first zero, at most KEY_BYTES of them
    function automatic logic [63:0] trim_key(input logic [63:0] raw);
        logic [63:0] kept;
        logic        alive;
        kept  = '0;
        alive = 1'b1;
        for (int n = 0; n < 8; n++) begin
            if (alive && (n < KEY_BYTES) && (raw[8*n +: 8] != 8'd0)) begin
                kept[8*n +: 8] = raw[8*n +: 8];
            end else begin
                alive = 1'b0;
            end
        end
        return kept;
    endfunction

    // Low bits of a slot index for the result field
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOT_W-1:0];
    endfunction

endpackage

### hdl/lphc_ram.sv
// Generic simple dual-port RAM with registered read.
module lphc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

### hdl/lphc_ctrl.sv
// Operation sequencer: decode, hash walk, probe loop and result issue.
module lphc_ctrl import lphc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [1:0] i_opcode,
    input  t_ctl_sts   i_sts,
    output t_ctl_cmd   o_cmd,
    output logic       o_busy
);

    t_state r_state, n_state;
    logic   r_insert, n_insert;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_insert <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_insert <= n_insert;
        end
    end

    // Next state
    always_comb begin
        n_state  = r_state;
        n_insert = r_insert;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_insert = (i_opcode == OP_INSERT);
                    if (((i_opcode == OP_LOOKUP) || (i_opcode == OP_INSERT)) && i_sts.ready) begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (i_sts.hash_last) begin
                    n_state = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                n_state = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (!i_sts.occupied || i_sts.lap_last || (!r_insert && i_sts.match)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PROBE_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.fin_status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    case (i_opcode)
                        OP_CLEAR: begin
                            o_cmd.clear  = 1'b1;
                            o_cmd.finish = 1'b1;
                        end
                        OP_LOOKUP, OP_INSERT: begin
                            if (!i_sts.ready) begin
                                o_cmd.finish     = 1'b1;
                                o_cmd.fin_status = ST_NOT_INIT;
                            end
                        end
                        default: begin
                            // unused code: report done, leave the table alone
                            o_cmd.finish = 1'b1;
                        end
                    endcase
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
            end
            S_PROBE_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            S_PROBE_CHK: begin
                if (r_insert) begin
                    if (!i_sts.occupied) begin
                        o_cmd.wr_en    = 1'b1;
                        o_cmd.finish   = 1'b1;
                        o_cmd.fin_slot = 1'b1;
                    end else if (i_sts.lap_last) begin
                        o_cmd.finish     = 1'b1;
                        o_cmd.fin_status = ST_FULL;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end else begin
                    if (!i_sts.occupied) begin
                        o_cmd.finish     = 1'b1;
                        o_cmd.fin_status = ST_NOT_FOUND;
                    end else if (i_sts.match) begin
                        o_cmd.finish      = 1'b1;
                        o_cmd.fin_payload = 1'b1;
                        o_cmd.fin_slot    = 1'b1;
                    end else if (i_sts.lap_last) begin
                        o_cmd.finish     = 1'b1;
                        o_cmd.fin_status = ST_NOT_FOUND;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### hdl/lphc_dp.sv
// Datapath: key trimming, byte-serial hash, probe index, entry store and result register.
module lphc_dp import lphc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in      i_cmd,
    input  t_ctl_cmd i_ctl,
    output t_ctl_sts o_sts,
    output t_out     o_result,
    output logic     o_res_valid
);

    logic [63:0]            r_k1, r_k2, r_payload;
    logic [127:0]           r_bytes;
    logic [63:0]            r_hash, n_hash;
    logic [STEP_W-1:0]      r_step;
    logic [IDX_W-1:0]       r_idx, r_lap;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic                   r_vld_q;
    logic                   r_ready;
    t_out                   r_res;
    logic                   r_res_valid;
    logic [ENTRY_W-1:0]     rd_data;
    logic [63:0]            rd_first, rd_second, rd_payload;

    // djb2 step: hash * 33 + byte, zero bytes past the end of a key leave it alone
    always_comb begin
        n_hash = r_hash;
        if (r_bytes[7:0] != 8'd0) begin
            n_hash = (r_hash << HASH_SHIFT) + r_hash + {56'd0, r_bytes[7:0]};
        end
    end

    // Operand capture, hash walk and probe index
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_k1      <= trim_key(i_cmd.first_key);
            r_k2      <= trim_key(i_cmd.second_key);
            r_payload <= i_cmd.payload_in;
            r_bytes   <= {trim_key(i_cmd.second_key), trim_key(i_cmd.first_key)};
            r_hash    <= HASH_START;
            r_step    <= '0;
        end else if (i_ctl.hash_step) begin
            r_hash  <= n_hash;
            r_bytes <= {8'd0, r_bytes[127:8]};
            r_step  <= r_step + 1'b1;
            if (o_sts.hash_last) begin
                r_idx <= n_hash[IDX_W-1:0];
                r_lap <= '0;
            end
        end else if (i_ctl.advance) begin
            r_idx <= r_idx + 1'b1;
            r_lap <= r_lap + 1'b1;
        end
    end

    // Entry store
    lphc_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (i_ctl.wr_en),
        .i_wr_addr(r_idx),
        .i_wr_data({r_payload, r_k2, r_k1}),
        .i_rd_en  (i_ctl.rd_en),
        .i_rd_addr(r_idx),
        .o_rd_data(rd_data)
    );

    assign rd_first   = rd_data[63:0];
    assign rd_second  = rd_data[127:64];
    assign rd_payload = rd_data[191:128];

    // Written flags and init flag; a clear resets every written flag and sets the init flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ready <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= '0;
            r_ready <= 1'b1;
        end else if (i_ctl.wr_en) begin
            r_valid[r_idx] <= 1'b1;
        end
    end

    // Flag read lines up with the registered RAM read
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_vld_q <= r_valid[r_idx];
        end
    end

    // Status back to the controller
    assign o_sts.ready     = r_ready;
    assign o_sts.hash_last = (r_step == STEP_W'(HASH_STEPS - 1));
    assign o_sts.occupied  = r_vld_q && (rd_first != 64'd0);
    assign o_sts.match     = (rd_first == r_k1) && (rd_second == r_k2);
    assign o_sts.lap_last  = (r_lap == IDX_W'(TABLE_DEPTH - 1));

    // Result register: one-cycle strobe per beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_ctl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_res.status      <= i_ctl.fin_status;
            r_res.payload_out <= i_ctl.fin_payload ? rd_payload : 64'd0;
            r_res.slot        <= i_ctl.fin_slot ? to_slot(r_idx) : 8'd0;
        end
    end

    assign o_result    = r_res;
    assign o_res_valid = r_res_valid;

endmodule

### hdl/linear_probe_hash_cache.sv
// Top level of the linear probe hash cache: controller plus datapath.
//
// Hash table with open addressing and linear probing, keyed by two strings of up to
// eight bytes each (zero-terminated, first character in the low byte) and holding a
// 64-bit record per entry. A command is taken when start is high and busy is low; its
// result appears on o_result for exactly one cycle with o_res_valid high, and must be
// taken then since the block cannot be held off. Clear, the unused opcode and any
// lookup or insert before the first clear finish at once: the result shows the cycle
// after the command. A lookup or insert runs a byte-serial djb2 hash over all sixteen
// key bytes, then probes the table slot by slot, each slot with a read state and then a
// check state, set by the registered read of the single entry RAM; it probes 1 to 256
// slots, and the next command can be given in the cycle the result shows. Clear empties
// the table through a per-slot written flag, so no clearing pass follows reset.
module linear_probe_hash_cache import lphc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_cmd,
    output t_out o_result,
    output logic o_res_valid
);

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;

    // Sequencer
    lphc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_opcode(i_cmd.opcode),
        .i_sts   (ctl_sts),
        .o_cmd   (ctl_cmd),
        .o_busy  (busy)
    );

    // Datapath and table
    lphc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_ctl      (ctl_cmd),
        .o_sts      (ctl_sts),
        .o_result   (o_result),
        .o_res_valid(o_res_valid)
    );

endmodule
